// File: rtl/core/tse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tse_pkg;

  // Header block geometry and field offsets.
  localparam int unsigned BlockBytes     = 512;
  localparam int unsigned PosW           = 9;
  localparam logic [PosW-1:0] SizeFirst  = 9'd124;
  localparam logic [PosW-1:0] SizeLast   = 9'd135;
  localparam logic [PosW-1:0] TypeOffset = 9'd156;
  localparam logic [PosW-1:0] LastPos    = 9'd511;

  // Character codes used by the header decode.
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharSeven = 8'h37;
  localparam logic [7:0] TypeDir   = 8'h35;
  localparam logic [7:0] TypeNul   = 8'h00;

  // Byte classification codes.
  localparam logic [1:0] KindHeader  = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindSkip    = 2'd2;

  // Header event codes.
  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvZero    = 3'd1;
  localparam logic [2:0] EvDir     = 3'd2;
  localparam logic [2:0] EvSkipped = 3'd3;
  localparam logic [2:0] EvFile    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_last;
  } item_t;

  typedef struct packed {
    logic [1:0]  byte_kind;
    logic [7:0]  out_byte;
    logic [2:0]  header_event;
    logic [31:0] file_size;
    logic        file_close;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/tse_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module tse_parser
  import tse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  output result_t         res
);

  logic [PosW-1:0] header_position, header_position_next;
  logic            block_all_zero, block_all_zero_next;
  logic [31:0]     size_accum, size_accum_next;
  logic            octal_stopped, octal_stopped_next;
  logic [7:0]      entry_type, entry_type_next;
  logic            in_payload, in_payload_next;
  logic [31:0]     bytes_left, bytes_left_next;
  logic [PosW-1:0] pad_left, pad_left_next;

  logic            is_regular;
  logic            zero_now;
  logic [PosW-1:0] pad;

  assign is_regular = (entry_type inside {CharZero, TypeNul});
  assign zero_now   = block_all_zero && (data_byte == 8'h00);
  // Padding up to the next block boundary is the negated low bits of the size.
  assign pad        = PosW'(0) - size_accum[PosW-1:0];

  // Next state and result for the byte at the parser input.
  always_comb begin
    header_position_next = header_position;
    block_all_zero_next  = block_all_zero;
    size_accum_next      = size_accum;
    octal_stopped_next   = octal_stopped;
    entry_type_next      = entry_type;
    in_payload_next      = in_payload;
    bytes_left_next      = bytes_left;
    pad_left_next        = pad_left;

    res              = '0;
    res.out_byte     = data_byte;
    res.byte_kind    = KindHeader;
    res.header_event = EvNone;

    if (in_payload) begin
      // Entry data first, then the padding to the block boundary.
      if (bytes_left != 32'd0) begin
        res.byte_kind   = is_regular ? KindPayload : KindSkip;
        bytes_left_next = bytes_left - 32'd1;
        res.file_close  = is_regular && (bytes_left == 32'd1);
        in_payload_next = (bytes_left != 32'd1) || (pad_left != '0);
      end else begin
        res.byte_kind   = KindSkip;
        pad_left_next   = pad_left - PosW'(1);
        in_payload_next = (pad_left != PosW'(1));
      end
    end else begin
      block_all_zero_next = zero_now;

      // Octal size field; the first non-digit ends it.
      if (header_position >= SizeFirst && header_position <= SizeLast && !octal_stopped) begin
        if (data_byte inside {[CharZero:CharSeven]}) begin
          size_accum_next = {size_accum[28:0], 3'b000} + {29'd0, data_byte[2:0]};
        end else begin
          octal_stopped_next = 1'b1;
        end
      end

      if (header_position == TypeOffset) begin
        entry_type_next = data_byte;
      end

      if (header_position == LastPos) begin
        // Header complete: report it and set up the data phase.
        if (zero_now) begin
          res.header_event = EvZero;
        end else if (entry_type == TypeDir) begin
          res.header_event = EvDir;
        end else if (!is_regular) begin
          res.header_event = EvSkipped;
          bytes_left_next  = size_accum;
          pad_left_next    = pad;
          in_payload_next  = (size_accum != 32'd0) || (pad != '0);
        end else begin
          res.header_event = EvFile;
          res.file_size    = size_accum;
          res.file_close   = (size_accum == 32'd0);
          bytes_left_next  = size_accum;
          pad_left_next    = pad;
          in_payload_next  = (size_accum != 32'd0) || (pad != '0);
        end
        header_position_next = '0;
        block_all_zero_next  = 1'b1;
        size_accum_next      = '0;
        octal_stopped_next   = 1'b0;
      end else begin
        header_position_next = header_position + PosW'(1);
      end
    end
  end

  // Parser state advances once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      block_all_zero  <= 1'b1;
      size_accum      <= '0;
      octal_stopped   <= 1'b0;
      entry_type      <= '0;
      in_payload      <= 1'b0;
      bytes_left      <= '0;
      pad_left        <= '0;
    end else if (step) begin
      header_position <= header_position_next;
      block_all_zero  <= block_all_zero_next;
      size_accum      <= size_accum_next;
      octal_stopped   <= octal_stopped_next;
      entry_type      <= entry_type_next;
      in_payload      <= in_payload_next;
      bytes_left      <= bytes_left_next;
      pad_left        <= pad_left_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tar_stream_extractor.sv
// Byte-serial tar archive parser.
// The item channel (item_valid, item_ready, item) takes one archive byte
// per word; the result channel (result_valid, result_ready, result) gives
// exactly one tagged word for every byte, in order.
// Each result tells whether the byte was header, file payload or skipped,
// passes the byte through, and on the last byte of a 512-byte header
// carries the header event and, for a regular file, its parsed size.
// file_close marks the last payload byte of a file, or the header byte of
// an empty file.
// An accepted word sits in the input register, then the parser writes its
// result into the output register. Throughput is one word per cycle while
// result_ready does not stall the output, set by the single parser stage.
// When result_ready is low the result register holds its word and the
// input register still takes one more word before item_ready drops.
// Reset empties both registers and returns the parser to the start of a
// header block with no file open.
`timescale 1ns / 1ps
`default_nettype none

module tar_stream_extractor
  import tse_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_ready,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_ready,
  output result_t    result
);

  logic    in_full;
  item_t   in_word;
  logic    advance;
  logic    step;
  result_t parsed;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !in_full || advance;
  assign step       = in_full && advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_ready) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_word <= item;
    end
  end

  tse_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_word.data_byte),
    .res       (parsed)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= parsed;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tse_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tse_checker
  import tse_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    item_valid,
  input wire logic    item_ready,
  input wire item_t   item,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  // A stalled result word holds until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // Nothing is shown in the cycle after reset.
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  // Header events only appear on header bytes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.header_event != EvNone |-> result.byte_kind == KindHeader)
    else $error("header event on a non-header byte");

  // A size is reported only with a regular file event.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.header_event != EvFile |-> result.file_size == 32'd0)
    else $error("file size without a file event");

  // Close on a header byte means an empty regular file.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.file_close && result.byte_kind == KindHeader
    |-> result.header_event == EvFile && result.file_size == 32'd0)
    else $error("close on header byte without an empty file");

endmodule

bind tar_stream_extractor tse_checker u_tse_checker (.*);

`default_nettype wire
